// File: rtl/core/earw_pkg.sv
// ----------------------------------------------------------------------------
// earw_pkg : shared types and constants of the edge-avoid random-walk control
// Mode and register codes, fixed-point constants for the turn-angle pick and
// the exponential average, and the stage enable bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package earw_pkg;

   localparam int unsigned SENSOR_W   = 16;
   localparam int unsigned ODOM_W     = 16;
   localparam int unsigned RAND_W     = 16;
   localparam int unsigned AVG_W      = 16;
   localparam int unsigned ANGLE_W    = 16;
   localparam int unsigned YAW_W      = 25;
   localparam int unsigned SPEED_W    = 18;
   localparam int unsigned TURN_W     = 17;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned COUNT_W    = 6;
   localparam int unsigned BTICKS_W   = 5;
   localparam int unsigned DONE_W     = 14;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned M_W        = 17;
   localparam int unsigned Q_W        = 15;

   // drive modes
   localparam logic [MODE_W-1:0] MODE_FWD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BACK = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ROT  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECISION_LEVEL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_TRACK_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKUP_TICKS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKUP_SPEED     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_SPEED       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DONE_ANGLE       = 3'd6;

   // register reset values
   localparam logic [SENSOR_W-1:0] RST_SENSOR_THRESHOLD = 16'd0;
   localparam logic [AVG_W-1:0]    RST_DECISION_LEVEL   = 16'd26214;
   localparam logic [15:0]         RST_INV_TRACK_WIDTH  = 16'd256;
   localparam logic [BTICKS_W-1:0] RST_BACKUP_TICKS     = 5'd15;
   localparam logic [15:0]         RST_BACKUP_SPEED     = 16'hE666;
   localparam logic [15:0]         RST_TURN_SPEED       = 16'd16384;
   localparam logic [DONE_W-1:0]   RST_DONE_ANGLE       = 14'd819;

   localparam logic [AVG_W-1:0]    AVG_ONE   = 16'd32768;
   localparam logic [COUNT_W-1:0]  COUNT_MAX = 6'd63;

   // turn angle in Q3.13 is round(m * ANG_NUM_K / ANG_DEN), m = 65535 + r for
   // a left turn and 131070 - r for a right turn (60 to 120 degrees)
   localparam logic [M_W-1:0] M_POS_BASE     = 17'd65535;
   localparam logic [M_W-1:0] M_NEG_BASE     = 17'd131070;
   localparam logic [25:0]    ANG_NUM_K      = 26'd35744343;
   localparam logic [27:0]    ANG_HALF       = 28'd136531250;
   localparam logic [28:0]    ANG_DEN        = 29'd273062500;
   // estimate of the quotient, within one of the true value
   localparam logic [17:0]    ANG_RECIP      = 18'd137260;
   localparam logic [19:0]    ANG_RECIP_RND  = 20'd524288;

   // divide by ten for the average: x * 838861 >> 23, exact for x below 2^22
   localparam logic [19:0]    EWMA_RECIP     = 20'd838861;

   typedef struct packed {
      logic s1;
      logic s2;
   } stage_en_type;

   // new = floor((9 * avg + 32768 * hit + 5) / 10)
   function automatic logic [AVG_W-1:0] ewma_next(input logic [AVG_W-1:0] avg,
                                                  input logic hit);
      logic [18:0] x;
      logic [38:0] prod;
      x = {avg, 3'b000} + {3'b000, avg} + (hit ? 19'd32768 : 19'd0) + 19'd5;
      prod = {20'd0, x} * {19'd0, EWMA_RECIP};
      return prod[38:23];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/earw_angle.sv
// ----------------------------------------------------------------------------
// earw_angle : turn-angle magnitude from the random offset
// Two stages: a reciprocal estimate of the quotient with the full numerator,
// then one remainder check that moves the estimate by at most one.
// ----------------------------------------------------------------------------
`default_nettype none

module earw_angle (
   input  logic                        clock,
   input  earw_pkg::stage_en_type      en,
   input  logic [earw_pkg::M_W-1:0]    m,
   output logic [earw_pkg::Q_W-1:0]    q
);
   import earw_pkg::*;

   logic [43:0]    num_ff, num_in;
   logic [Q_W-1:0] q0_ff, q0_in;
   logic [Q_W-1:0] q_ff, q_in;
   logic [34:0]    est;
   logic [43:0]    back;
   logic [44:0]    rem;

   always_comb begin
      est   = 35'(m) * 35'(ANG_RECIP) + 35'(ANG_RECIP_RND);
      q0_in = est[34:20];
      num_in = 44'(m) * 44'(ANG_NUM_K) + 44'(ANG_HALF);
   end

   always_comb begin
      back = 44'(q0_ff) * 44'(ANG_DEN);
      rem  = {1'b0, num_ff} - {1'b0, back};
      if (rem[44]) begin
         q_in = q0_ff - 15'd1;
      end else if (rem >= 45'(ANG_DEN)) begin
         q_in = q0_ff + 15'd1;
      end else begin
         q_in = q0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         num_ff <= num_in;
         q0_ff  <= q0_in;
      end
      if (en.s2) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

`default_nettype wire

// File: rtl/core/edge_avoid_random_walk_ctrl.sv
// ----------------------------------------------------------------------------
// edge_avoid_random_walk_ctrl : grass-edge avoiding random-walk drive control
// Per tick: threshold the grass sensors, update the per-side averages and run
// the forward / back-up / rotate machine, giving speed, turn and mode.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  req     | req_valid/req_ready  | sensors, wheel odometry, random word
//  rsp     | rsp_valid/rsp_ready  | speed_cmd, turn_cmd, mode_now
//  csr     | csr_we               | csr_index, csr_wdata (seven registers)
//
//  one word per cycle unless the result side stalls; each tick passes the
//  stages (threshold, yaw and angle estimate; angle correction; mode machine)
//  the averages and the mode machine update in the last stage only
//  reset clears the stage valids and presets the machine state and registers
//  a stalled result holds its stage; req_ready drops only once every stage
//  behind it is full
//
`default_nettype none

module edge_avoid_random_walk_ctrl (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [earw_pkg::SENSOR_W-1:0]          req_sensor_left,
   input  logic [earw_pkg::SENSOR_W-1:0]          req_sensor_right,
   input  logic signed [earw_pkg::ODOM_W-1:0]     req_odom_right,
   input  logic signed [earw_pkg::ODOM_W-1:0]     req_odom_left,
   input  logic [earw_pkg::RAND_W-1:0]            req_random_word,

   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [earw_pkg::SPEED_W-1:0]    rsp_speed_cmd,
   output logic signed [earw_pkg::TURN_W-1:0]     rsp_turn_cmd,
   output logic [earw_pkg::MODE_W-1:0]            rsp_mode_now,

   input  logic                                   csr_we,
   input  logic [earw_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [earw_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import earw_pkg::*;

   // configuration
   logic [SENSOR_W-1:0]  thr_ff, thr_in;
   logic [AVG_W-1:0]     dl_ff, dl_in;
   logic [15:0]          itw_ff, itw_in;
   logic [BTICKS_W-1:0]  bt_ff, bt_in;
   logic [15:0]          bs_ff, bs_in;
   logic [15:0]          ts_ff, ts_in;
   logic [DONE_W-1:0]    da_ff, da_in;

   // stage flow
   logic v0_ff, v0_in, v1_ff, v1_in, v2_ff, v2_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic r0, r1, r2, r_out, fire;
   stage_en_type en;

   // stage 0: input register
   logic [SENSOR_W-1:0]  sl0_ff, sr0_ff;
   logic [ODOM_W-1:0]    odr0_ff, odl0_ff;
   logic [RAND_W-1:0]    rnd0_ff;

   // stage 1 and 2
   logic                 hit_l1_ff, hit_l1_in, hit_r1_ff, hit_r1_in;
   logic [YAW_W-1:0]     yaw1_ff, yaw1_in;
   logic                 hit_l2_ff, hit_r2_ff;
   logic signed [YAW_W-1:0] yaw2_ff;
   logic [M_W-1:0]       m_pos, m_neg;
   logic [Q_W-1:0]       q_pos, q_neg;
   logic [16:0]          odo_diff;
   logic signed [33:0]   yaw_a, yaw_b, yaw_prod;

   // machine state
   logic [AVG_W-1:0]     avg_l_ff, avg_l_in, avg_r_ff, avg_r_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic signed [ANGLE_W-1:0] angle_ff, angle_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;

   // results
   logic signed [SPEED_W-1:0] rsp_speed_ff, rsp_speed_in;
   logic signed [TURN_W-1:0]  rsp_turn_ff, rsp_turn_in;
   logic [MODE_W-1:0]         rsp_mode_ff, rsp_mode_in;

   // machine decode
   logic                 fwd, edge_hit, good, in_back, back_done, in_rot, rot_done;
   logic                 a_pos, yaw_covers;
   logic [COUNT_W-1:0]   cnt_base;
   logic [16:0]          mag;
   logic signed [YAW_W-1:0] a_ext;
   logic signed [25:0]   a_diff;

   // ---------------------------------------------------------------- flow
   always_comb begin
      r_out = !rsp_valid_ff || rsp_ready;
      r2    = !v2_ff || r_out;
      r1    = !v1_ff || r2;
      r0    = !v0_ff || r1;
      fire  = v2_ff && r_out;
      en.s1 = r1;
      en.s2 = r2;
      v0_in = r0 ? req_valid : v0_ff;
      v1_in = r1 ? v0_ff : v1_ff;
      v2_in = r2 ? v1_ff : v2_ff;
      rsp_valid_in = r_out ? v2_ff : rsp_valid_ff;
   end

   assign req_ready = r0;

   // ---------------------------------------------------------------- config
   always_comb begin
      thr_in = thr_ff;
      dl_in  = dl_ff;
      itw_in = itw_ff;
      bt_in  = bt_ff;
      bs_in  = bs_ff;
      ts_in  = ts_ff;
      da_in  = da_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SENSOR_THRESHOLD: thr_in = csr_wdata;
            CSR_DECISION_LEVEL:   dl_in  = csr_wdata;
            CSR_INV_TRACK_WIDTH:  itw_in = csr_wdata;
            CSR_BACKUP_TICKS:     bt_in  = csr_wdata[BTICKS_W-1:0];
            CSR_BACKUP_SPEED:     bs_in  = csr_wdata;
            CSR_TURN_SPEED:       ts_in  = csr_wdata;
            CSR_DONE_ANGLE:       da_in  = csr_wdata[DONE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- stage 1
   always_comb begin
      hit_l1_in = sl0_ff > thr_ff;
      hit_r1_in = sr0_ff > thr_ff;
      odo_diff  = {odr0_ff[ODOM_W-1], odr0_ff} - {odl0_ff[ODOM_W-1], odl0_ff};
      yaw_a     = {{17{odo_diff[16]}}, odo_diff};
      yaw_b     = {18'd0, itw_ff};
      yaw_prod  = yaw_a * yaw_b;
      // arithmetic shift by eight floors towards minus infinity
      yaw1_in   = yaw_prod[32:8];
      m_pos     = M_POS_BASE + {1'b0, rnd0_ff};
      m_neg     = M_NEG_BASE - {1'b0, rnd0_ff};
   end

   earw_angle u_angle_pos (
      .clock (clock),
      .en    (en),
      .m     (m_pos),
      .q     (q_pos)
   );

   earw_angle u_angle_neg (
      .clock (clock),
      .en    (en),
      .m     (m_neg),
      .q     (q_neg)
   );

   // ---------------------------------------------------------------- machine
   always_comb begin
      avg_l_in = ewma_next(avg_l_ff, hit_l2_ff);
      avg_r_in = ewma_next(avg_r_ff, hit_r2_ff);

      fwd      = (mode_ff != MODE_BACK) && (mode_ff != MODE_ROT);
      edge_hit = fwd && ((avg_l_in < dl_ff) || (avg_r_in < dl_ff));
      good     = (avg_l_in > dl_ff) && (avg_r_in > dl_ff);
      in_back  = edge_hit || (mode_ff == MODE_BACK);
      cnt_base = edge_hit ? '0 : cnt_ff;
      back_done = in_back && good && (cnt_base > {1'b0, bt_ff});
      // an edge never finishes backing in the same tick, so rotation sees
      // the stored angle
      in_rot   = (mode_ff == MODE_ROT) || back_done;

      mag      = angle_ff[ANGLE_W-1] ? (17'd0 - {1'b1, angle_ff}) : {1'b0, angle_ff};
      rot_done = mag < {3'b000, da_ff};

      a_pos    = !angle_ff[ANGLE_W-1] && (angle_ff != '0);
      a_ext    = {{(YAW_W-ANGLE_W){angle_ff[ANGLE_W-1]}}, angle_ff};
      yaw_covers = a_pos ? (yaw2_ff >= a_ext) : (yaw2_ff <= a_ext);
      a_diff   = {a_ext[YAW_W-1], a_ext} - {yaw2_ff[YAW_W-1], yaw2_ff};

      rsp_speed_in = '0;
      rsp_turn_in  = '0;
      mode_in      = mode_ff;
      angle_in     = angle_ff;
      cnt_in       = cnt_ff;

      if (fwd && !edge_hit) begin
         mode_in      = MODE_FWD;
         rsp_speed_in = {2'b00, avg_l_in} + {2'b00, avg_r_in} - {1'b0, dl_ff, 1'b0};
      end

      if (edge_hit) begin
         if (avg_l_in > avg_r_in) begin
            angle_in = {1'b0, q_pos};
         end else begin
            angle_in = 16'd0 - {1'b0, q_neg};
         end
      end

      if (in_back) begin
         if (good && (cnt_base != COUNT_MAX)) begin
            cnt_in = cnt_base + 6'd1;
         end else begin
            cnt_in = cnt_base;
         end
         if (back_done) begin
            mode_in = MODE_ROT;
         end else begin
            mode_in      = MODE_BACK;
            rsp_speed_in = {{(SPEED_W-16){bs_ff[15]}}, bs_ff};
         end
      end

      if (in_rot) begin
         if (rot_done) begin
            mode_in      = MODE_FWD;
            rsp_speed_in = '0;
         end else begin
            mode_in      = MODE_ROT;
            rsp_speed_in = '0;
            rsp_turn_in  = a_pos ? {1'b0, ts_ff} : (17'd0 - {1'b0, ts_ff});
            if (yaw_covers) begin
               angle_in = '0;
            end else if (a_diff > 26'sd32767) begin
               angle_in = 16'sh7FFF;
            end else if (a_diff < -26'sd32768) begin
               angle_in = 16'sh8000;
            end else begin
               angle_in = a_diff[ANGLE_W-1:0];
            end
         end
      end

      rsp_mode_in = mode_in;
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= RST_SENSOR_THRESHOLD;
         dl_ff        <= RST_DECISION_LEVEL;
         itw_ff       <= RST_INV_TRACK_WIDTH;
         bt_ff        <= RST_BACKUP_TICKS;
         bs_ff        <= RST_BACKUP_SPEED;
         ts_ff        <= RST_TURN_SPEED;
         da_ff        <= RST_DONE_ANGLE;
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         avg_l_ff     <= AVG_ONE;
         avg_r_ff     <= AVG_ONE;
         mode_ff      <= MODE_FWD;
         angle_ff     <= '0;
         cnt_ff       <= '0;
      end else begin
         thr_ff       <= thr_in;
         dl_ff        <= dl_in;
         itw_ff       <= itw_in;
         bt_ff        <= bt_in;
         bs_ff        <= bs_in;
         ts_ff        <= ts_in;
         da_ff        <= da_in;
         v0_ff        <= v0_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            avg_l_ff <= avg_l_in;
            avg_r_ff <= avg_r_in;
            mode_ff  <= mode_in;
            angle_ff <= angle_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (r0) begin
         sl0_ff  <= req_sensor_left;
         sr0_ff  <= req_sensor_right;
         odr0_ff <= req_odom_right;
         odl0_ff <= req_odom_left;
         rnd0_ff <= req_random_word;
      end
      if (en.s1) begin
         hit_l1_ff <= hit_l1_in;
         hit_r1_ff <= hit_r1_in;
         yaw1_ff   <= yaw1_in;
      end
      if (en.s2) begin
         hit_l2_ff <= hit_l1_ff;
         hit_r2_ff <= hit_r1_ff;
         yaw2_ff   <= yaw1_ff;
      end
      if (fire) begin
         rsp_speed_ff <= rsp_speed_in;
         rsp_turn_ff  <= rsp_turn_in;
         rsp_mode_ff  <= rsp_mode_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_speed_cmd = rsp_speed_ff;
   assign rsp_turn_cmd  = rsp_turn_ff;
   assign rsp_mode_now  = rsp_mode_ff;

   // ---------------------------------------------------------------- checks
   a_rot_no_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_mode_ff == MODE_ROT) |-> rsp_speed_ff == '0)
      else $error("speed commanded while rotating");

   a_turn_only_rot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_mode_ff != MODE_ROT) |-> rsp_turn_ff == '0)
      else $error("turn commanded outside rotation");

   a_backup_count_cleared: assert property (@(posedge clock) disable iff (reset)
      fire && edge_hit |=> (cnt_ff <= 6'd1) && (mode_ff == MODE_BACK))
      else $error("back-up count not cleared on edge");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !r_out |=> v2_ff && $stable(yaw2_ff))
      else $error("stalled word lost from last stage");

endmodule

`default_nettype wire

// File: tb/edge_avoid_random_walk_ctrl_test.sv
// ----------------------------------------------------------------------------
// edge_avoid_random_walk_ctrl_test : self-checking bench for the edge-avoid
// random-walk drive controller
// Every tick taken is run through a cycle-free model of the sensor averages
// and the forward / back-up / rotate machine. The command it gives is queued,
// and each result word is compared field by field with the oldest one. The
// run covers a directed walk through an edge, back-up and rotation, then
// random phases under several register settings with random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_avoid_random_walk_ctrl_test;
   import earw_pkg::*;

   localparam int unsigned STALL_LIMIT     = 2000;
   localparam int unsigned HOLD_CYCLES     = 120;
   localparam int unsigned HOLD_AFTER      = 250;
   localparam int unsigned ITEMS_PER_PHASE = 300;
   localparam int unsigned NUM_PHASES      = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam longint DEG_SPAN           = 65535;
   localparam longint RAD_Q13_PER_DEG_E6 = 142977372;

   typedef struct packed {
      logic signed [SPEED_W-1:0] speed;
      logic signed [TURN_W-1:0]  turn;
      logic [MODE_W-1:0]         mode;
   } drive_cmd_type;

   class tick_scoreboard;
      logic [15:0]          sensor_thr, level, inv_track, turn_rate;
      logic [BTICKS_W-1:0]  good_ticks;
      logic signed [15:0]   back_rate;
      logic [DONE_W-1:0]    done_thr;
      int                   avg_l, avg_r, angle, backup_cnt;
      logic [MODE_W-1:0]    mode;
      drive_cmd_type        pending_cmds[$];
      int                   errors;
      int                   n_checked;

      function new();
         sensor_thr = RST_SENSOR_THRESHOLD;
         level      = RST_DECISION_LEVEL;
         inv_track  = RST_INV_TRACK_WIDTH;
         good_ticks = RST_BACKUP_TICKS;
         back_rate  = RST_BACKUP_SPEED;
         turn_rate  = RST_TURN_SPEED;
         done_thr   = RST_DONE_ANGLE;
         avg_l      = int'(AVG_ONE);
         avg_r      = int'(AVG_ONE);
         angle      = 0;
         backup_cnt = 0;
         mode       = MODE_FWD;
         errors     = 0;
         n_checked  = 0;
      endfunction

      task report(string what);
         $display("mismatch at result %0d: %s", n_checked, what);
         errors++;
      endtask

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] v);
         case (idx)
            CSR_SENSOR_THRESHOLD: sensor_thr = v;
            CSR_DECISION_LEVEL:   level = v;
            CSR_INV_TRACK_WIDTH:  inv_track = v;
            CSR_BACKUP_TICKS:     good_ticks = v[BTICKS_W-1:0];
            CSR_BACKUP_SPEED:     back_rate = v;
            CSR_TURN_SPEED:       turn_rate = v;
            CSR_DONE_ANGLE:       done_thr = v[DONE_W-1:0];
            default: ;
         endcase
      endfunction

      // 60..120 degrees in q3.13 radians, rounded half away from zero
      function int turn_angle(logic [15:0] rnd, bit left_more);
         longint span, den, q;
         den = DEG_SPAN * 1000000;
         span = left_more ? 60 * DEG_SPAN + 60 * longint'(rnd)
                          : 120 * DEG_SPAN - 60 * longint'(rnd);
         q = (span * RAD_Q13_PER_DEG_E6 + den / 2) / den;
         return left_more ? int'(q) : -int'(q);
      endfunction

      function void predict_tick(logic [15:0] sl, logic [15:0] sr,
                                 logic signed [15:0] odr, logic signed [15:0] odl,
                                 logic [15:0] rnd);
         longint        speed, turn, yaw, a, lvl, mag;
         bit            good, done;
         drive_cmd_type cmd;
         lvl = longint'(level);
         speed = 0;
         turn = 0;
         avg_l = (9 * avg_l + (sl > sensor_thr ? 32768 : 0) + 5) / 10;
         avg_r = (9 * avg_r + (sr > sensor_thr ? 32768 : 0) + 5) / 10;

         if (mode != MODE_BACK && mode != MODE_ROT) begin
            mode = MODE_FWD;
            if (avg_l < lvl || avg_r < lvl) begin
               angle = turn_angle(rnd, avg_l > avg_r);
               backup_cnt = 0;
               mode = MODE_BACK;
            end else begin
               speed = avg_l + avg_r - 2 * lvl;
            end
         end

         if (mode == MODE_BACK) begin
            good = avg_l > lvl && avg_r > lvl;
            done = 0;
            if (good) begin
               done = backup_cnt > int'(good_ticks);
               if (backup_cnt < int'(COUNT_MAX)) backup_cnt++;
            end
            turn = 0;
            if (done) begin
               speed = 0;
               mode = MODE_ROT;
            end else begin
               speed = longint'(back_rate);
            end
         end

         // falls straight through from a finished back-up
         if (mode == MODE_ROT) begin
            a = angle;
            mag = a < 0 ? -a : a;
            if (mag < longint'(done_thr)) begin
               speed = 0;
               turn = 0;
               mode = MODE_FWD;
            end else begin
               yaw = ((longint'(odr) - longint'(odl)) * longint'(inv_track)) >>> 8;
               speed = 0;
               turn = a > 0 ? longint'(turn_rate) : -longint'(turn_rate);
               if (a > 0) a = a - (a < yaw ? a : yaw);
               else a = a + ((-a) < (-yaw) ? -a : -yaw);
               angle = a > 32767 ? 32767 : (a < -32768 ? -32768 : int'(a));
            end
         end

         cmd.speed = speed[SPEED_W-1:0];
         cmd.turn  = turn[TURN_W-1:0];
         cmd.mode  = mode;
         pending_cmds.push_back(cmd);
      endfunction

      task check_cmd(logic signed [SPEED_W-1:0] speed, logic signed [TURN_W-1:0] turn,
                     logic [MODE_W-1:0] mode_now);
         drive_cmd_type want;
         if (pending_cmds.size() == 0) begin
            report($sformatf("unexpected word speed %0d turn %0d mode %0d",
                             speed, turn, mode_now));
         end else begin
            want = pending_cmds.pop_front();
            if (speed !== want.speed)
               report($sformatf("speed_cmd %0d, wanted %0d", speed, want.speed));
            if (turn !== want.turn)
               report($sformatf("turn_cmd %0d, wanted %0d", turn, want.turn));
            if (mode_now !== want.mode)
               report($sformatf("mode_now %0d, wanted %0d", mode_now, want.mode));
         end
         n_checked++;
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [SENSOR_W-1:0]        req_sensor_left = '0;
   logic [SENSOR_W-1:0]        req_sensor_right = '0;
   logic signed [ODOM_W-1:0]   req_odom_right = '0;
   logic signed [ODOM_W-1:0]   req_odom_left = '0;
   logic [RAND_W-1:0]          req_random_word = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SPEED_W-1:0]  rsp_speed_cmd;
   logic signed [TURN_W-1:0]   rsp_turn_cmd;
   logic [MODE_W-1:0]          rsp_mode_now;
   logic                       csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   tick_scoreboard sb = new();
   bit             calm = 1'b0;
   int             run_l = 0;
   int             run_r = 0;

   edge_avoid_random_walk_ctrl dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sensor_left  (req_sensor_left),
      .req_sensor_right (req_sensor_right),
      .req_odom_right   (req_odom_right),
      .req_odom_left    (req_odom_left),
      .req_random_word  (req_random_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_speed_cmd    (rsp_speed_cmd),
      .rsp_turn_cmd     (rsp_turn_cmd),
      .rsp_mode_now     (rsp_mode_now),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.set_reg(csr_index, csr_wdata);
         if (req_valid && req_ready)
            sb.predict_tick(req_sensor_left, req_sensor_right, req_odom_right,
                            req_odom_left, req_random_word);
         if (rsp_valid && rsp_ready) sb.check_cmd(rsp_speed_cmd, rsp_turn_cmd, rsp_mode_now);
      end
   end

   // result side: random stalls plus one long hold-off so the pipe backs up
   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && sb.n_checked >= HOLD_AFTER) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || $urandom_range(99) >= 10;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) quiet = 0;
         else quiet++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_tick(logic [15:0] sl, logic [15:0] sr, logic [15:0] odr,
                            logic [15:0] odl, logic [15:0] rnd);
      @(negedge clock);
      req_valid        <= 1'b1;
      req_sensor_left  <= sl;
      req_sensor_right <= sr;
      req_odom_right   <= odr;
      req_odom_left    <= odl;
      req_random_word  <= rnd;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic sender_gap();
      while (!calm && $urandom_range(99) < 10) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   task automatic apply_regs(logic [15:0] thr, logic [15:0] lvl, logic [15:0] itw,
                             logic [15:0] bt, logic [15:0] bs, logic [15:0] ts,
                             logic [15:0] da);
      write_reg(CSR_SENSOR_THRESHOLD, thr);
      write_reg(CSR_DECISION_LEVEL, lvl);
      write_reg(CSR_INV_TRACK_WIDTH, itw);
      write_reg(CSR_BACKUP_TICKS, bt);
      write_reg(CSR_BACKUP_SPEED, bs);
      write_reg(CSR_TURN_SPEED, ts);
      write_reg(CSR_DONE_ANGLE, da);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // stop offering and wait for every outstanding word
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_cmds.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // reading on or off grass for the present threshold, often right at it
   function automatic logic [15:0] sensor_word(bit grass);
      logic [15:0] thr;
      thr = sb.sensor_thr;
      if (grass && thr != 16'hFFFF) begin
         if ($urandom_range(99) < 15) return thr + 16'd1;
         return 16'($urandom_range(65535, int'(thr) + 1));
      end
      if ($urandom_range(99) < 15) return thr;
      return 16'($urandom_range(int'(thr), 0));
   endfunction

   task automatic random_tick();
      int base, diff, side, len;
      bit toward;
      if ($urandom_range(99) < 8) begin
         send_tick(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)));
      end else begin
         // now and then one or both sides run off the grass for a few ticks
         if (run_l == 0 && run_r == 0 && $urandom_range(99) < 5) begin
            side = $urandom_range(2);
            len = $urandom_range(7, 2);
            if (side != 1) run_l = len;
            if (side != 0) run_r = len;
         end
         // wheel difference mostly winds the remaining angle down
         toward = $urandom_range(99) < 80;
         diff = $urandom_range(3000, 50);
         if ((sb.angle > 0) != toward) diff = -diff;
         base = int'($urandom_range(2000)) - 1000;
         send_tick(sensor_word(run_l == 0), sensor_word(run_r == 0), 16'(base + diff),
                   16'(base), 16'($urandom_range(65535)));
         if (run_l > 0) run_l--;
         if (run_r > 0) run_r--;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed walk: fast back-up exit so one edge runs through every mode
      apply_regs(16'd0, RST_DECISION_LEVEL, RST_INV_TRACK_WIDTH, 16'd0, RST_BACKUP_SPEED,
                 RST_TURN_SPEED, 16'(RST_DONE_ANGLE));
      send_tick(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF);
      send_tick(16'h0001, 16'h0001, 16'h8000, 16'h7FFF, 16'h0000);
      // both sides off together: averages equal at the edge, turn goes right
      repeat (3) send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      repeat (3) send_tick(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      // back-up ends and rotation starts at once, wheels against the turn
      send_tick(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000);
      send_tick(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000);
      send_tick(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      repeat (4) send_tick(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      drain();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         calm = (phase == 1);
         case (phase)
            0: apply_regs(RST_SENSOR_THRESHOLD, RST_DECISION_LEVEL, RST_INV_TRACK_WIDTH,
                          16'(RST_BACKUP_TICKS), RST_BACKUP_SPEED, RST_TURN_SPEED,
                          16'(RST_DONE_ANGLE));
            1: apply_regs(16'd0, 16'd32768, 16'hFFFF, 16'd0, 16'h8000, 16'd32768,
                          16'd8192);
            2: apply_regs(16'd30000, 16'd20000, 16'd512, 16'd3, 16'hFC18, 16'd1000,
                          16'd0);
            3: apply_regs(16'hFFFF, 16'd0, 16'd0, 16'd31, 16'd0, 16'd0, 16'd0);
            4: begin
               write_reg(CSR_UNMAPPED, 16'($urandom_range(65535)));
               apply_regs(16'($urandom_range(40000)),
                          ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                                   : 16'($urandom_range(32768, 16000)),
                          16'($urandom_range(65535)), 16'($urandom_range(65535)),
                          16'($urandom_range(65535)), 16'($urandom_range(65535)),
                          16'($urandom_range(65535)));
            end
            default: apply_regs(RST_SENSOR_THRESHOLD, RST_DECISION_LEVEL,
                                RST_INV_TRACK_WIDTH, 16'(RST_BACKUP_TICKS),
                                RST_BACKUP_SPEED, RST_TURN_SPEED, 16'(RST_DONE_ANGLE));
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            sender_gap();
            random_tick();
         end
         drain();
      end

      repeat (16) @(negedge clock);
      if (sb.errors == 0 && sb.pending_cmds.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
